@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the mesh interpolator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent holds, consequent holds on the next clock.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ rtl/core/tmpi_pkg.sv @@
// Package of the triangle mesh point interpolator: item kinds, register
// indexes, select codes and the controller/datapath command and status types.
package tmpi_pkg;

    localparam int IDX_W     = 10;  // node / element index field width
    localparam int CFG_W     = 11;  // configuration register width
    localparam int CFG_IDX_W = 8;   // configuration index width

    typedef enum logic [1:0] {
        KIND_NODE,
        KIND_ELEM,
        KIND_VALUE,
        KIND_QUERY
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_COUNT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_COUNT = 8'd1;

    typedef enum logic [1:0] {
        CORNER_A,
        CORNER_B,
        CORNER_C
    } t_corner;

    typedef enum logic [1:0] {
        CR_FULL,
        CR_W0,
        CR_W1,
        CR_W2
    } t_cross;

    typedef struct packed {
        logic    q_start;
        logic    corn_ld;
        t_corner node_rd_sel;
        logic    node_ld;
        t_corner node_ld_sel;
        logic    cross_en;
        t_cross  cross_sel;
        logic    mul_en;
        t_corner mul_sel;
        logic    acc_clr;
        logic    set_found;
        logic    div_init;
        logic    div_step;
        logic    elem_next;
    } t_dp_cmd;

    typedef struct packed {
        logic e_done;
        logic nodes_ok;
        logic hit;
    } t_dp_sts;

endpackage

@@ rtl/core/triangle_mesh_point_interpolator_unit.sv @@
// Top level of the triangle mesh point interpolator: ports, configuration
// registers, output register. Depends on tmpi_pkg, tmpi_ctrl, tmpi_dp and assert_macros.svh.
//
// Node, element and value writes give no result.
// A query walks the elements in order: an element whose corners are out of
// range is dropped after the corner fetch; a tested element goes through
// corner fetch, three node reads on the single read port of the node stores,
// four cross products on one shared multiplier pair and a compare. The first
// hit then goes through the weighted sum, a divider setup step and a
// restoring divider, and its result is loaded into the output register. One
// query is in flight at a time and o_stall stays high until its result is in
// the output register, longer while that register is still held by i_stall.
// The stores have no reset; their contents are defined once written.
module triangle_mesh_point_interpolator_unit import tmpi_pkg::*; #(
    parameter int MAX_NODES    = 1024,
    parameter int MAX_ELEMENTS = 1024,
    parameter int COORD_BITS   = 16,
    parameter int VALUE_BITS   = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input item channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_kind,
    input  logic [IDX_W-1:0]             i_slot,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic [IDX_W-1:0]             i_corner_a,
    input  logic [IDX_W-1:0]             i_corner_b,
    input  logic [IDX_W-1:0]             i_corner_c,
    input  logic signed [VALUE_BITS-1:0] i_field_value,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [VALUE_BITS-1:0] o_interp_value,
    output logic                         o_found,
    output logic [IDX_W-1:0]             o_hit_element,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data
);

    `include "assert_macros.svh"

    logic                         in_acc, query_acc, busy, out_load, out_free;
    t_dp_cmd                      cmd;
    t_dp_sts                      sts;
    logic [CFG_W-1:0]             r_elem_count, r_value_count;
    logic signed [VALUE_BITS-1:0] dp_value;
    logic                         dp_found;
    logic [IDX_W-1:0]             dp_hit;
    logic                         r_out_valid;
    logic signed [VALUE_BITS-1:0] r_out_value;
    logic                         r_out_found;
    logic [IDX_W-1:0]             r_out_hit;

    assign o_stall   = busy;
    assign in_acc    = i_valid && !busy;
    assign query_acc = in_acc && (t_kind'(i_kind) == KIND_QUERY);
    assign out_free  = !r_out_valid || !i_stall;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count  <= '0;
            r_value_count <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ELEM_COUNT)  r_elem_count  <= i_cfg_data;
            if (i_cfg_index == CFG_VALUE_COUNT) r_value_count <= i_cfg_data;
        end
    end

    tmpi_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_query(query_acc), .i_sts(sts),
        .i_out_free(out_free), .o_cmd(cmd), .o_busy(busy), .o_out_load(out_load));

    tmpi_dp #(
        .MAX_NODES(MAX_NODES), .MAX_ELEMENTS(MAX_ELEMENTS),
        .COORD_BITS(COORD_BITS), .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc(in_acc), .i_kind(i_kind),
        .i_slot(i_slot), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_corner_a(i_corner_a), .i_corner_b(i_corner_b), .i_corner_c(i_corner_c),
        .i_field_value(i_field_value), .i_elem_count(r_elem_count),
        .i_value_count(r_value_count), .i_cmd(cmd), .o_sts(sts),
        .o_interp_value(dp_value), .o_found(dp_found), .o_hit_element(dp_hit));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= dp_value;
            r_out_found <= dp_found;
            r_out_hit   <= dp_hit;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_interp_value = r_out_value;
    assign o_found        = r_out_found;
    assign o_hit_element  = r_out_hit;

    // checks
    `ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, query_acc, o_stall, "query did not start")
    `ASSERT_CLK(a_load_free, i_clk, i_rst_n, out_load |-> out_free, "output overwritten")
    `ASSERT_CLK(a_miss_zero, i_clk, i_rst_n, (r_out_valid && !r_out_found) |-> ((r_out_value == '0) && (r_out_hit == '0)), "miss result not zero")

endmodule

@@ rtl/core/tmpi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tmpi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tmpi_ctrl.sv @@
// Sequencer of the mesh interpolator: walks elements, steps the cross
// products, weighted sum and divider. Depends on tmpi_pkg.
module tmpi_ctrl import tmpi_pkg::*; #(
    parameter int VALUE_BITS = 24
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_query,
    input  t_dp_sts i_sts,
    input  logic    i_out_free,
    output t_dp_cmd o_cmd,
    output logic    o_busy,
    output logic    o_out_load
);

    localparam int DCW = $clog2(VALUE_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_ELEM, S_CORN, S_NA, S_NB, S_NC, S_NL,
        S_XP, S_CHK, S_MUL, S_DINIT, S_DIV, S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_k, n_k;
    logic [DCW-1:0]   r_dcnt, n_dcnt;

    // next state and step counters
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_dcnt  = r_dcnt;
        unique case (r_state)
            S_IDLE:  if (i_query) n_state = S_ELEM;
            S_ELEM:  n_state = i_sts.e_done ? S_OUT : S_CORN;
            S_CORN:  n_state = S_NA;
            S_NA:    n_state = i_sts.nodes_ok ? S_NB : S_ELEM;
            S_NB:    n_state = S_NC;
            S_NC:    n_state = S_NL;
            S_NL: begin
                n_state = S_XP;
                n_k     = 2'd0;
            end
            S_XP: begin
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) n_state = S_CHK;
            end
            S_CHK: begin
                n_k     = 2'd0;
                n_state = i_sts.hit ? S_MUL : S_ELEM;
            end
            S_MUL: begin
                n_k = r_k + 2'd1;
                if (r_k == 2'd2) n_state = S_DINIT;
            end
            S_DINIT: begin
                n_dcnt  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_dcnt = r_dcnt + DCW'(1);
                if (r_dcnt == DCW'(VALUE_BITS - 1)) n_state = S_OUT;
            end
            S_OUT:   if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_dcnt  <= n_dcnt;
        end
    end

    // command decode
    always_comb begin
        o_cmd             = '0;
        o_cmd.node_rd_sel = CORNER_A;
        o_cmd.node_ld_sel = CORNER_A;
        o_cmd.cross_sel   = t_cross'(r_k);
        o_cmd.mul_sel     = t_corner'(r_k);
        o_out_load        = 1'b0;
        unique case (r_state)
            S_IDLE:  o_cmd.q_start = i_query;
            S_ELEM:  ;
            S_CORN:  o_cmd.corn_ld = 1'b1;
            S_NA: begin
                o_cmd.node_rd_sel = CORNER_A;
                o_cmd.elem_next   = !i_sts.nodes_ok;
            end
            S_NB: begin
                o_cmd.node_ld     = 1'b1;
                o_cmd.node_ld_sel = CORNER_A;
                o_cmd.node_rd_sel = CORNER_B;
            end
            S_NC: begin
                o_cmd.node_ld     = 1'b1;
                o_cmd.node_ld_sel = CORNER_B;
                o_cmd.node_rd_sel = CORNER_C;
            end
            S_NL: begin
                o_cmd.node_ld     = 1'b1;
                o_cmd.node_ld_sel = CORNER_C;
            end
            S_XP:    o_cmd.cross_en = 1'b1;
            S_CHK: begin
                o_cmd.set_found = i_sts.hit;
                o_cmd.acc_clr   = i_sts.hit;
                o_cmd.elem_next = !i_sts.hit;
            end
            S_MUL:   o_cmd.mul_en   = 1'b1;
            S_DINIT: o_cmd.div_init = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_OUT:   o_out_load     = i_out_free;
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ rtl/core/tmpi_dp.sv @@
// Datapath of the mesh interpolator: mesh stores, corner fetch, cross
// products, weighted sum and restoring divider. Depends on tmpi_pkg, tmpi_ram.
module tmpi_dp import tmpi_pkg::*; #(
    parameter int MAX_NODES    = 1024,
    parameter int MAX_ELEMENTS = 1024,
    parameter int COORD_BITS   = 16,
    parameter int VALUE_BITS   = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_acc,
    input  logic [1:0]                   i_kind,
    input  logic [IDX_W-1:0]             i_slot,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic [IDX_W-1:0]             i_corner_a,
    input  logic [IDX_W-1:0]             i_corner_b,
    input  logic [IDX_W-1:0]             i_corner_c,
    input  logic signed [VALUE_BITS-1:0] i_field_value,
    input  logic [CFG_W-1:0]             i_elem_count,
    input  logic [CFG_W-1:0]             i_value_count,
    input  t_dp_cmd                      i_cmd,
    output t_dp_sts                      o_sts,
    output logic signed [VALUE_BITS-1:0] o_interp_value,
    output logic                         o_found,
    output logic [IDX_W-1:0]             o_hit_element
);

    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EAW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW  = 3 * IDX_W;
    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int XW  = PW + 1;
    localparam int SW  = XW + 2;
    localparam int TW  = XW + 1 + VALUE_BITS;
    localparam int AW  = XW + VALUE_BITS + 3;
    localparam logic [16:0] NODE_LIM = 17'(MAX_NODES);
    localparam logic [16:0] ELEM_LIM = 17'(MAX_ELEMENTS);

    // ---------------- store writes ----------------
    logic                  node_we, elem_we, val_we;
    logic [NAW+IDX_W-1:0]  slot_n_ext;
    logic [EAW+IDX_W-1:0]  slot_e_ext;
    logic [NAW-1:0]        node_waddr, node_raddr;
    logic [EAW-1:0]        elem_waddr, elem_raddr;
    logic [EAW+CFG_W-1:0]  e_ext;
    logic [NAW+IDX_W-1:0]  ridx_ext;
    logic [IDX_W-1:0]      ridx;

    assign slot_n_ext = {{NAW{1'b0}}, i_slot};
    assign slot_e_ext = {{EAW{1'b0}}, i_slot};
    assign node_waddr = slot_n_ext[NAW-1:0];
    assign elem_waddr = slot_e_ext[EAW-1:0];
    assign node_we = i_acc && (t_kind'(i_kind) == KIND_NODE)
                     && ({7'd0, i_slot} < NODE_LIM);
    assign elem_we = i_acc && (t_kind'(i_kind) == KIND_ELEM)
                     && ({7'd0, i_slot} < ELEM_LIM);
    assign val_we  = i_acc && (t_kind'(i_kind) == KIND_VALUE)
                     && ({7'd0, i_slot} < NODE_LIM);

    // ---------------- registers ----------------
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [CFG_W-1:0]             r_e;
    logic [IDX_W-1:0]             r_ia, r_ib, r_ic;
    logic signed [COORD_BITS-1:0] r_xa, r_ya, r_xb, r_yb, r_xc, r_yc;
    logic signed [VALUE_BITS-1:0] r_va, r_vb, r_vc;
    logic [XW-1:0]                r_full, r_w0, r_w1, r_w2;
    logic signed [AW-1:0]         r_acc;
    logic [AW-1:0]                r_rem, r_div;
    logic [VALUE_BITS-1:0]        r_quo;
    logic                         r_neg, r_found;

    // read addresses
    assign e_ext      = {{EAW{1'b0}}, r_e};
    assign elem_raddr = e_ext[EAW-1:0];
    always_comb begin
        unique case (i_cmd.node_rd_sel)
            CORNER_A: ridx = r_ia;
            CORNER_B: ridx = r_ib;
            CORNER_C: ridx = r_ic;
            default:  ridx = r_ia;
        endcase
    end
    assign ridx_ext   = {{NAW{1'b0}}, ridx};
    assign node_raddr = ridx_ext[NAW-1:0];

    // ---------------- stores ----------------
    logic [CW-1:0]         corn_rd;
    logic [COORD_BITS-1:0] nx_rd, ny_rd;
    logic [VALUE_BITS-1:0] nv_rd;

    tmpi_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_NODES)) u_node_x (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr),
        .i_wdata(i_coord_x), .i_raddr(node_raddr), .o_rdata(nx_rd));
    tmpi_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_NODES)) u_node_y (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr),
        .i_wdata(i_coord_y), .i_raddr(node_raddr), .o_rdata(ny_rd));
    tmpi_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_NODES)) u_value (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(node_waddr),
        .i_wdata(i_field_value), .i_raddr(node_raddr), .o_rdata(nv_rd));
    tmpi_ram #(.WIDTH(CW), .DEPTH(MAX_ELEMENTS)) u_corner (
        .i_clk(i_clk), .i_we(elem_we), .i_waddr(elem_waddr),
        .i_wdata({i_corner_c, i_corner_b, i_corner_a}),
        .i_raddr(elem_raddr), .o_rdata(corn_rd));

    // ---------------- cross product unit ----------------
    logic signed [COORD_BITS-1:0] ox, oy, p1x, p1y, p2x, p2y;
    logic signed [DW-1:0]         dx1, dy1, dx2, dy2;
    logic signed [PW-1:0]         m1, m2;
    logic signed [XW-1:0]         cr;
    logic [XW-1:0]                cr_abs;

    always_comb begin
        ox = r_px;  oy = r_py;
        p1x = r_xb; p1y = r_yb;
        p2x = r_xc; p2y = r_yc;
        unique case (i_cmd.cross_sel)
            CR_FULL: begin
                ox = r_xa; oy = r_ya;
            end
            CR_W0: ;
            CR_W1: begin
                p1x = r_xc; p1y = r_yc;
                p2x = r_xa; p2y = r_ya;
            end
            CR_W2: begin
                p1x = r_xa; p1y = r_ya;
                p2x = r_xb; p2y = r_yb;
            end
            default: ;
        endcase
    end

    assign dx1    = DW'(p1x) - DW'(ox);
    assign dy1    = DW'(p1y) - DW'(oy);
    assign dx2    = DW'(p2x) - DW'(ox);
    assign dy2    = DW'(p2y) - DW'(oy);
    assign m1     = dx1 * dy2;
    assign m2     = dx2 * dy1;
    assign cr     = XW'(m1) - XW'(m2);
    assign cr_abs = cr[XW-1] ? XW'(-cr) : XW'(cr);

    // ---------------- weighted term ----------------
    logic [XW-1:0]                mw;
    logic signed [VALUE_BITS-1:0] mv;
    logic [IDX_W-1:0]             midx;
    logic signed [TW-1:0]         term;
    logic                         contrib;

    always_comb begin
        unique case (i_cmd.mul_sel)
            CORNER_A: begin mw = r_w0; mv = r_va; midx = r_ia; end
            CORNER_B: begin mw = r_w1; mv = r_vb; midx = r_ib; end
            CORNER_C: begin mw = r_w2; mv = r_vc; midx = r_ic; end
            default:  begin mw = '0;   mv = '0;   midx = '0;   end
        endcase
    end
    assign contrib = ({1'b0, midx} < i_value_count);
    assign term    = $signed({1'b0, mw}) * mv;

    // divider compare
    logic div_ge;
    assign div_ge = (r_rem >= r_div);

    // ---------------- status ----------------
    logic [SW-1:0] wsum;
    assign wsum = SW'(r_w0) + SW'(r_w1) + SW'(r_w2);
    assign o_sts.hit      = (r_full != '0) && (wsum == SW'(r_full));
    assign o_sts.nodes_ok = ({7'd0, r_ia} < NODE_LIM) && ({7'd0, r_ib} < NODE_LIM)
                            && ({7'd0, r_ic} < NODE_LIM);
    assign o_sts.e_done   = (r_e >= i_elem_count) || (17'(r_e) >= ELEM_LIM);

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e     <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.q_start) begin
                r_e     <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.elem_next) r_e <= r_e + CFG_W'(1);
                if (i_cmd.set_found) r_found <= 1'b1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (i_cmd.corn_ld) begin
            r_ia <= corn_rd[IDX_W-1:0];
            r_ib <= corn_rd[2*IDX_W-1:IDX_W];
            r_ic <= corn_rd[3*IDX_W-1:2*IDX_W];
        end
        if (i_cmd.node_ld) begin
            unique case (i_cmd.node_ld_sel)
                CORNER_A: begin r_xa <= nx_rd; r_ya <= ny_rd; r_va <= nv_rd; end
                CORNER_B: begin r_xb <= nx_rd; r_yb <= ny_rd; r_vb <= nv_rd; end
                CORNER_C: begin r_xc <= nx_rd; r_yc <= ny_rd; r_vc <= nv_rd; end
                default: ;
            endcase
        end
        if (i_cmd.cross_en) begin
            unique case (i_cmd.cross_sel)
                CR_FULL: r_full <= cr_abs;
                CR_W0:   r_w0   <= cr_abs;
                CR_W1:   r_w1   <= cr_abs;
                CR_W2:   r_w2   <= cr_abs;
                default: ;
            endcase
        end
        // weighted sum accumulate
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.mul_en && contrib) begin
            r_acc <= r_acc + AW'(term);
        end
        // restoring divide of |sum| by full area, one quotient bit a cycle
        if (i_cmd.div_init) begin
            r_neg <= r_acc[AW-1];
            r_rem <= r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
            r_div <= AW'(r_full) << (VALUE_BITS - 1);
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (div_ge) r_rem <= r_rem - r_div;
            r_quo <= {r_quo[VALUE_BITS-2:0], div_ge};
            r_div <= r_div >> 1;
        end
    end

    // result, truncated toward zero
    assign o_interp_value = !r_found ? '0
                          : (r_neg ? -$signed(r_quo) : $signed(r_quo));
    assign o_found        = r_found;
    assign o_hit_element  = r_found ? r_e[IDX_W-1:0] : '0;

endmodule

@@ bench/tb_triangle_mesh_point_interpolator_unit.sv @@
// Self-checking bench for the triangle mesh point interpolator: builds meshes,
// fires query points and compares every result with a behavioral predictor.
// Depends on tmpi_pkg and triangle_mesh_point_interpolator_unit.
module tb_triangle_mesh_point_interpolator_unit;
    import tmpi_pkg::*;

    localparam int NODES = 1024;
    localparam int ELEMS = 1024;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 8'hFF;

    typedef struct packed {
        logic signed [23:0] value;
        logic               found;
        logic [9:0]         hit;
    } t_interp_result;

    // Mesh mirror, register copies and queue of pending interpolation results
    class t_mesh_scoreboard;
        logic signed [15:0] nx [NODES];
        logic signed [15:0] ny [NODES];
        logic [9:0]         ca [ELEMS];
        logic [9:0]         cb [ELEMS];
        logic [9:0]         cc [ELEMS];
        logic signed [23:0] nval [NODES];
        int unsigned        elem_cnt;
        int unsigned        val_cnt;
        t_interp_result     pending_q [$];
        int                 errors;
        int                 n_queries;
        int                 n_hits;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_ELEM_COUNT) elem_cnt = data;
            else if (idx == CFG_VALUE_COUNT) val_cnt = data;
        endfunction

        function longint cross2(longint ax, longint ay, longint bx, longint by);
            return ax * by - bx * ay;
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // First qualifying element wins; weights are doubled sub-areas
        function t_interp_result locate(longint px, longint py);
            t_interp_result r;
            int unsigned    lim, e;
            int             k;
            logic [9:0]     idx [3];
            longint         x [3], y [3], w [3];
            longint         full, total;
            r = '0;
            lim = (elem_cnt < ELEMS) ? elem_cnt : ELEMS;
            for (e = 0; e < lim; e++) begin
                idx[0] = ca[e];
                idx[1] = cb[e];
                idx[2] = cc[e];
                for (k = 0; k < 3; k++) begin
                    x[k] = nx[idx[k]];
                    y[k] = ny[idx[k]];
                end
                full = mag(cross2(x[1] - x[0], y[1] - y[0], x[2] - x[0], y[2] - y[0]));
                if (full == 0) continue;
                w[0] = mag(cross2(x[1] - px, y[1] - py, x[2] - px, y[2] - py));
                w[1] = mag(cross2(x[2] - px, y[2] - py, x[0] - px, y[0] - py));
                w[2] = mag(cross2(x[0] - px, y[0] - py, x[1] - px, y[1] - py));
                if (w[0] + w[1] + w[2] != full) continue;
                total = 0;
                for (k = 0; k < 3; k++)
                    if (idx[k] < val_cnt) total += w[k] * longint'(nval[idx[k]]);
                total = total / full;  // truncates toward zero
                r.value = total[23:0];
                r.found = 1'b1;
                r.hit   = e[9:0];
                return r;
            end
            return r;
        endfunction

        function void note_item(t_kind kind, logic [9:0] slot, logic signed [15:0] x,
                                logic signed [15:0] y, logic [9:0] a, logic [9:0] b,
                                logic [9:0] c, logic signed [23:0] v);
            t_interp_result r;
            case (kind)
                KIND_NODE: begin
                    nx[slot] = x;
                    ny[slot] = y;
                end
                KIND_ELEM: begin
                    ca[slot] = a;
                    cb[slot] = b;
                    cc[slot] = c;
                end
                KIND_VALUE: nval[slot] = v;
                default: begin
                    r = locate(x, y);
                    pending_q.push_back(r);
                    n_queries++;
                    if (r.found) n_hits++;
                end
            endcase
        endfunction

        function void check_result(logic signed [23:0] v, logic f, logic [9:0] h);
            t_interp_result exp_r;
            if (pending_q.size() == 0) begin
                $error("result with no query outstanding: value %0d found %0b", v, f);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (v !== exp_r.value) begin
                $error("interp_value: expected %0d, got %0d", exp_r.value, v);
                errors++;
            end
            if (f !== exp_r.found) begin
                $error("found: expected %0b, got %0b", exp_r.found, f);
                errors++;
            end
            if (h !== exp_r.hit) begin
                $error("hit_element: expected %0d, got %0d", exp_r.hit, h);
                errors++;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                i_clk, i_rst_n;
    logic                i_valid, o_stall;
    logic [1:0]          i_kind;
    logic [IDX_W-1:0]    i_slot;
    logic signed [15:0]  i_coord_x, i_coord_y;
    logic [IDX_W-1:0]    i_corner_a, i_corner_b, i_corner_c;
    logic signed [23:0]  i_field_value;
    logic                o_valid, i_stall;
    logic signed [23:0]  o_interp_value;
    logic                o_found;
    logic [IDX_W-1:0]    o_hit_element;
    logic                i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;

    t_mesh_scoreboard sb = new();
    int  node_pool [$];
    bit  quiet;
    bit  hold_req;
    int  elems_built;

    triangle_mesh_point_interpolator_unit u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
            end else begin
                n = idle_len();
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(negedge i_clk);
                end
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_interp_value, o_found, o_hit_element);

    // One input transaction; unused fields carry random junk
    task automatic send_item(t_kind kind, int slot, int x, int y, int a, int b, int c, int v);
        int n;
        n = idle_len();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_kind        <= kind;
        i_slot        <= slot[9:0];
        i_coord_x     <= x[15:0];
        i_coord_y     <= y[15:0];
        i_corner_a    <= a[9:0];
        i_corner_b    <= b[9:0];
        i_corner_c    <= c[9:0];
        i_field_value <= v[23:0];
        i_valid       <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(kind, slot[9:0], x[15:0], y[15:0], a[9:0], b[9:0], c[9:0], v[23:0]);
        @(negedge i_clk);
    endtask

    task automatic put_node(int slot, int x, int y);
        send_item(KIND_NODE, slot, x, y, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic put_value(int slot, int v);
        send_item(KIND_VALUE, slot, $urandom, $urandom, $urandom, $urandom, $urandom, v);
    endtask

    task automatic put_elem(int slot, int a, int b, int c);
        send_item(KIND_ELEM, slot, $urandom, $urandom, a, b, c, $urandom);
    endtask

    task automatic query_at(int x, int y);
        send_item(KIND_QUERY, $urandom, x, y, $urandom, $urandom, $urandom, $urandom);
    endtask

    function automatic int pick_node();
        return node_pool[$urandom_range(0, node_pool.size() - 1)];
    endfunction

    // Element with corners from written nodes; sometimes a repeated corner
    task automatic put_rand_elem(int slot);
        int a, b;
        a = pick_node();
        b = pick_node();
        if ($urandom_range(0, 9) == 0) put_elem(slot, a, b, a);
        else put_elem(slot, a, b, pick_node());
    endtask

    // Point as a convex blend of the element's corners (edges and corners too)
    task automatic query_in_elem(int e);
        longint wa, wb, wc, s, px, py;
        wa = $urandom_range(0, 7);
        wb = $urandom_range(0, 7);
        wc = $urandom_range(0, 7);
        if (wa + wb + wc == 0) wa = 1;
        s  = wa + wb + wc;
        px = (wa * sb.nx[sb.ca[e]] + wb * sb.nx[sb.cb[e]] + wc * sb.nx[sb.cc[e]]) / s;
        py = (wa * sb.ny[sb.ca[e]] + wb * sb.ny[sb.cb[e]] + wc * sb.ny[sb.cc[e]]) / s;
        query_at(int'(px), int'(py));
    endtask

    // Config writes only once the input side is idle and the block has drained
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_W-1:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data[CFG_W-1:0]);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int ec, int vc, int count);
        int i, p;
        write_reg(CFG_ELEM_COUNT, ec);
        write_reg(CFG_VALUE_COUNT, vc);
        for (i = 0; i < count; i++) begin
            p = $urandom_range(0, 99);
            if (p < 6) put_node(pick_node(), $urandom_range(0, 4000) - 2000,
                                $urandom_range(0, 4000) - 2000);
            else if (p < 12) put_value(pick_node(), $urandom);
            else if (p < 18) put_rand_elem($urandom_range(0, elems_built - 1));
            else if (p < 82 && ec > 0)
                query_in_elem($urandom_range(0, ((ec < elems_built) ? ec : elems_built) - 1));
            else query_at($urandom, $urandom);
        end
    endtask

    initial begin
        int i;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = KIND_NODE;
        i_slot = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_corner_a = '0;
        i_corner_b = '0;
        i_corner_c = '0;
        i_field_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty mesh: nothing is searched
        query_at(0, 0);

        // Node pool: small indices plus high ones that toggle every index bit
        for (i = 0; i < 12; i++) node_pool.push_back(i);
        node_pool.push_back(341);
        node_pool.push_back(682);
        node_pool.push_back(512);
        node_pool.push_back(1023);
        put_node(0, 0, 0);
        put_node(1, 100, 0);
        put_node(2, 0, 100);
        put_node(3, 50, 0);
        put_node(1023, -32768, -32768);
        put_node(682, 32767, -32768);
        put_node(341, 0, 32767);
        put_node(512, 32767, 32767);
        for (i = 4; i < 12; i++)
            put_node(i, $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000);
        put_value(0, -8388608);
        put_value(1, 8388607);
        put_value(2, 1000);
        put_value(1023, 8388607);
        put_value(682, -8388608);
        put_value(341, -77);
        put_value(512, 5);
        for (i = 3; i < 12; i++) put_value(i, $urandom);

        // Degenerate, collinear, small, full-range, then random elements
        put_elem(0, 0, 0, 1);
        put_elem(1, 0, 3, 1);
        put_elem(2, 0, 1, 2);
        put_elem(3, 1023, 682, 341);
        for (i = 4; i < 16; i++) put_rand_elem(i);
        elems_built = 16;

        write_reg(CFG_ELEM_COUNT, 4);
        write_reg(CFG_VALUE_COUNT, 1024);
        write_reg(CFG_IDX_UNUSED_LO, 0);
        write_reg(CFG_IDX_UNUSED_HI, 0);
        query_at(0, 0);            // shared corner of degenerate and real elements
        query_at(50, 0);           // on an edge
        query_at(33, 33);          // inside
        query_at(50, 50);          // on the hypotenuse
        query_at(0, 32767);        // corner of the full-range element
        query_at(-32768, 32767);   // outside everything
        query_at(32767, 32767);
        write_reg(CFG_VALUE_COUNT, 0);
        query_at(20, 30);          // values all masked off
        write_reg(CFG_VALUE_COUNT, 2);
        query_at(20, 30);          // only the low corners contribute

        // Random phases; the first holds the result side off for a long stretch
        hold_req = 1'b1;
        random_phase(8, 1024, 110);
        quiet = 1'b1;
        random_phase(3, 5, 100);
        quiet = 1'b0;
        random_phase(16, 2047, 110);
        random_phase(1, 0, 80);
        random_phase(12, 700, 110);
        random_phase(0, 1024, 20);

        // Counts beyond the store depth and at its limit; element 0 is rebuilt
        // as a known triangle so every search ends on it
        put_node(0, 0, 0);
        put_node(1, 100, 0);
        put_node(2, 0, 100);
        put_elem(0, 0, 1, 2);
        write_reg(CFG_ELEM_COUNT, 2047);
        write_reg(CFG_VALUE_COUNT, 1024);
        query_at(33, 33);
        query_in_elem(0);
        write_reg(CFG_ELEM_COUNT, ELEMS);
        query_at(10, 10);

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d queries (%0d inside the mesh) over several mesh and count setups,",
                 sb.n_queries, sb.n_hits);
        $display("including empty, degenerate, edge-point and oversized-count searches.");
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
